// ----- sv/itia_pkg.sv -----
// shared types, codes and reset constants for the interval timer interrupt adapter
package itia_pkg;

  // item action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // register addresses
  localparam logic [3:0] REG_PORT_A  = 4'd0;
  localparam logic [3:0] REG_PORT_B  = 4'd1;
  localparam logic [3:0] REG_DDR_A   = 4'd2;
  localparam logic [3:0] REG_TA_LO   = 4'd4;
  localparam logic [3:0] REG_TA_HI   = 4'd5;
  localparam logic [3:0] REG_TB_LO   = 4'd6;
  localparam logic [3:0] REG_TB_HI   = 4'd7;
  localparam logic [3:0] REG_SERIAL  = 4'd12;
  localparam logic [3:0] REG_ICR     = 4'd13;
  localparam logic [3:0] REG_CTRL_A  = 4'd14;
  localparam logic [3:0] REG_CTRL_B  = 4'd15;

  // flag latch bits
  localparam logic [7:0] FLAG_TA     = 8'h01;
  localparam logic [7:0] FLAG_TB     = 8'h02;
  localparam logic [7:0] FLAG_ALARM  = 8'h04;
  localparam logic [7:0] FLAG_SERIAL = 8'h08;
  localparam logic [7:0] FLAG_IRQ    = 8'h80;

  // timer b input modes (control bits 6:5)
  localparam logic [1:0] MODE_CYCLES  = 2'b00;
  localparam logic [1:0] MODE_CASCADE = 2'b10;

  // control byte load strobe is never stored
  localparam logic [7:0] CTRL_STORE_MASK = 8'hEF;

  // bits shifted per serial byte
  localparam logic [3:0] SERIAL_BITS = 4'd8;

  // port reset values per unit
  localparam logic [7:0] PORT_A_UNIT1 = 8'd127;
  localparam logic [7:0] PORT_A_UNIT0 = 8'd151;
  localparam logic [7:0] PORT_B_INIT  = 8'd255;
  localparam logic [7:0] DDR_A_UNIT1  = 8'd255;
  localparam logic [7:0] DDR_A_UNIT0  = 8'd63;

  typedef logic [7:0] regfile_t [16];

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] delta_cycles;
    logic       alarm_event;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pending;
    logic [7:0] port_b_value;
  } result_t;

  // register file contents after reset or a unit select write
  function automatic regfile_t regfile_init(input logic unit);
    regfile_t rf;
    for (int i = 0; i < 16; i++) begin
      rf[i] = 8'h00;
    end
    rf[REG_PORT_A] = unit ? PORT_A_UNIT1 : PORT_A_UNIT0;
    rf[REG_PORT_B] = PORT_B_INIT;
    rf[REG_DDR_A]  = unit ? DDR_A_UNIT1 : DDR_A_UNIT0;
    return rf;
  endfunction

endpackage

// ----- sv/itia_ifs.sv -----
// channel interfaces: input items, result items and the configuration write

interface itia_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] delta_cycles;
  logic       alarm_event;

  modport source (output valid, action, reg_index, write_data, delta_cycles, alarm_event,
                  input ready);
  modport sink   (input valid, action, reg_index, write_data, delta_cycles, alarm_event,
                  output ready);
endinterface

interface itia_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_pending;
  logic [7:0] port_b_value;

  modport source (output valid, read_data, irq_pending, port_b_value, input ready);
  modport sink   (input valid, read_data, irq_pending, port_b_value, output ready);
endinterface

interface itia_cfg_if;
  logic valid;
  logic ready;
  logic unit_select;

  modport source (output valid, unit_select, input ready);
  modport sink   (input valid, unit_select, output ready);
endinterface

// ----- sv/itia_core.sv -----
// register file, timers, serial counter and flag latch with their one-item update
module itia_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  itia_pkg::item_t item,
  input  logic            cfg_write,
  input  logic            cfg_unit,
  output itia_pkg::result_t result
);
  import itia_pkg::*;

  // architectural state
  regfile_t    rf;
  logic [15:0] count_a;
  logic [15:0] count_b;
  logic [15:0] reload_a;
  logic [15:0] reload_b;
  logic [7:0]  flag_latch;
  logic        a_underflowed;
  logic [3:0]  bits_left;
  logic [3:0]  bits_queued;

  regfile_t    rf_next;
  logic [15:0] count_a_next;
  logic [15:0] count_b_next;
  logic [15:0] reload_a_next;
  logic [15:0] reload_b_next;
  logic [7:0]  flag_latch_next;
  logic        a_underflowed_next;
  logic [3:0]  bits_left_next;
  logic [3:0]  bits_queued_next;
  logic [7:0]  read_data;

  // next state for the item in the input register
  always_comb begin
    logic [7:0] mask;
    logic [7:0] ctl;
    logic       b_run;
    rf_next            = rf;
    count_a_next       = count_a;
    count_b_next       = count_b;
    reload_a_next      = reload_a;
    reload_b_next      = reload_b;
    flag_latch_next    = flag_latch;
    a_underflowed_next = a_underflowed;
    bits_left_next     = bits_left;
    bits_queued_next   = bits_queued;
    read_data          = 8'h00;
    mask               = rf[REG_ICR];
    ctl                = 8'h00;
    b_run              = 1'b0;

    unique case (item.action)
      ACT_TICK: begin
        // alarm flag
        if (item.alarm_event) begin
          flag_latch_next = flag_latch_next | FLAG_ALARM;
          if ((mask & FLAG_ALARM) != 8'h00) flag_latch_next = flag_latch_next | FLAG_IRQ;
        end

        // timer a, counting cycles only
        ctl = rf[REG_CTRL_A];
        if (ctl[0] && !ctl[5]) begin
          count_a_next = (count_a > {8'h00, item.delta_cycles})
                       ? count_a - {8'h00, item.delta_cycles} : 16'h0000;
          if (count_a_next == 16'h0000) begin
            a_underflowed_next = 1'b1;
            if (ctl[1] && !ctl[2]) rf_next[REG_PORT_B][6] = ~rf_next[REG_PORT_B][6];
            if (!ctl[3]) begin
              count_a_next = reload_a;
            end else begin
              rf_next[REG_CTRL_A][0] = 1'b0;
            end
            flag_latch_next = flag_latch_next | FLAG_TA;
            if ((mask & FLAG_TA) != 8'h00) flag_latch_next = flag_latch_next | FLAG_IRQ;
            // serial bit count
            if (rf_next[REG_CTRL_A][6] && bits_left != 4'd0) begin
              bits_left_next = bits_left - 4'd1;
              if (bits_left_next == 4'd0) begin
                flag_latch_next = flag_latch_next | FLAG_SERIAL;
                if ((mask & FLAG_SERIAL) != 8'h00) flag_latch_next = flag_latch_next | FLAG_IRQ;
                if (bits_queued != 4'd0) begin
                  bits_left_next   = bits_queued;
                  bits_queued_next = 4'd0;
                end
              end
            end
          end
        end

        // timer b, cycles or timer a underflows
        ctl = rf[REG_CTRL_B];
        if (ctl[0]) begin
          if (ctl[6:5] == MODE_CYCLES) begin
            b_run        = 1'b1;
            count_b_next = (count_b > {8'h00, item.delta_cycles})
                         ? count_b - {8'h00, item.delta_cycles} : 16'h0000;
          end else if (ctl[6:5] == MODE_CASCADE) begin
            b_run = 1'b1;
            if (a_underflowed_next) begin
              a_underflowed_next = 1'b0;
              count_b_next       = count_b - 16'd1;
            end
          end
        end
        if (b_run && count_b_next == 16'h0000) begin
          if (ctl[1] && !ctl[2]) rf_next[REG_PORT_B][7] = ~rf_next[REG_PORT_B][7];
          if (!ctl[3]) begin
            count_b_next = reload_b;
          end else begin
            rf_next[REG_CTRL_B][0] = 1'b0;
          end
          flag_latch_next = flag_latch_next | FLAG_TB;
          if ((mask & FLAG_TB) != 8'h00) flag_latch_next = flag_latch_next | FLAG_IRQ;
        end
      end

      ACT_READ: begin
        unique case (item.reg_index)
          REG_TA_LO: read_data = count_a[7:0];
          REG_TA_HI: read_data = count_a[15:8];
          REG_TB_LO: read_data = count_b[7:0];
          REG_TB_HI: read_data = count_b[15:8];
          REG_ICR: begin
            read_data       = flag_latch;
            flag_latch_next = 8'h00;
          end
          default: read_data = rf[item.reg_index];
        endcase
      end

      ACT_WRITE: begin
        unique case (item.reg_index)
          REG_TA_LO: reload_a_next[7:0] = item.write_data;
          REG_TA_HI: begin
            reload_a_next[15:8] = item.write_data;
            if (!rf[REG_CTRL_A][0]) count_a_next = reload_a_next;
          end
          REG_TB_LO: reload_b_next[7:0] = item.write_data;
          REG_TB_HI: begin
            reload_b_next[15:8] = item.write_data;
            if (!rf[REG_CTRL_B][0]) count_b_next = reload_b_next;
          end
          REG_SERIAL: begin
            if (bits_left == 4'd0) begin
              bits_left_next = SERIAL_BITS;
            end else begin
              bits_queued_next = SERIAL_BITS;
            end
            rf_next[REG_SERIAL] = item.write_data;
          end
          REG_ICR: begin
            if (item.write_data[7]) begin
              rf_next[REG_ICR] = rf[REG_ICR] | item.write_data;
            end else begin
              rf_next[REG_ICR] = rf[REG_ICR] & ~(item.write_data | FLAG_IRQ);
            end
          end
          REG_CTRL_A: begin
            rf_next[REG_CTRL_A] = item.write_data & CTRL_STORE_MASK;
            if (item.write_data[4]) count_a_next = reload_a;
          end
          REG_CTRL_B: begin
            rf_next[REG_CTRL_B] = item.write_data & CTRL_STORE_MASK;
            if (item.write_data[4]) count_b_next = reload_b;
          end
          default: rf_next[item.reg_index] = item.write_data;
        endcase
      end

      default: begin
        // unused action leaves the state alone
      end
    endcase
  end

  // result of this item
  assign result.read_data    = read_data;
  assign result.irq_pending  = flag_latch_next[7];
  assign result.port_b_value = rf_next[REG_PORT_B];

  // state registers: reset and unit select writes clear the whole block
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      rf            <= regfile_init(rst ? 1'b1 : cfg_unit);
      count_a       <= 16'h0000;
      count_b       <= 16'h0000;
      reload_a      <= 16'h0000;
      reload_b      <= 16'h0000;
      flag_latch    <= 8'h00;
      a_underflowed <= 1'b0;
      bits_left     <= 4'd0;
      bits_queued   <= 4'd0;
    end else if (step) begin
      rf            <= rf_next;
      count_a       <= count_a_next;
      count_b       <= count_b_next;
      reload_a      <= reload_a_next;
      reload_b      <= reload_b_next;
      flag_latch    <= flag_latch_next;
      a_underflowed <= a_underflowed_next;
      bits_left     <= bits_left_next;
      bits_queued   <= bits_queued_next;
    end
  end

endmodule

// ----- sv/interval_timer_interrupt_adapter.sv -----
// Interval timer interrupt adapter: a 16-register peripheral with two interval
// timers, a serial bit counter and an interrupt flag latch.
//
// Channels: items (valid/ready) carries one tick, register read or register
// write per transfer; results (valid/ready) returns one result per item with
// the read byte, the interrupt summary bit and port B; cfg (valid/ready) writes
// unit_select, clearing timer and register state to that unit's port values.
// cfg is always ready; users must write it only while idle; it is not enforced.
//
// An accepted item sits in the input register, is processed there against the
// timer and register state, and its result lands in the output register once
// that register is empty or being read; the result can then itself transfer.
// One item per cycle is sustained while results does not stall; the state
// update is the loop that sets this rate.
//
// Reset (rst, synchronous) selects unit 1 and clears all state and both
// pipeline registers. When results stalls, the output register holds its
// result and the input register, if empty, still takes one more item before
// items.ready drops.
module interval_timer_interrupt_adapter (
  input  logic          clk,
  input  logic          rst,
  itia_cfg_if.sink      cfg,
  itia_item_if.sink     items,
  itia_result_if.source results
);
  import itia_pkg::*;

  item_t   item_q;
  logic    item_valid;
  result_t res_q;
  logic    res_valid;
  result_t core_result;
  logic    step;
  logic    cfg_write;

  // handshakes
  assign step        = item_valid && (!res_valid || results.ready);
  assign items.ready = !item_valid || step;
  assign cfg.ready   = 1'b1;
  assign cfg_write   = cfg.valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.ready) begin
      item_valid <= items.valid;
    end
    if (items.ready) begin
      item_q.action       <= items.action;
      item_q.reg_index    <= items.reg_index;
      item_q.write_data   <= items.write_data;
      item_q.delta_cycles <= items.delta_cycles;
      item_q.alarm_event  <= items.alarm_event;
    end
  end

  // timer and register state
  itia_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item_q),
    .cfg_write (cfg_write),
    .cfg_unit  (cfg.unit_select),
    .result    (core_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
    if (step) begin
      res_q <= core_result;
    end
  end

  assign results.valid        = res_valid;
  assign results.read_data    = res_q.read_data;
  assign results.irq_pending  = res_q.irq_pending;
  assign results.port_b_value = res_q.port_b_value;

endmodule

// ----- dv/tb_top.sv -----
// testbench for the interval timer interrupt adapter: random ticks and bus accesses checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import itia_pkg::*;

  // action code the block ignores
  localparam logic [1:0] ACT_IDLE = 2'd3;

  // control register bits
  localparam logic [7:0] CTL_START   = 8'h01;
  localparam logic [7:0] CTL_PB_ON   = 8'h02;
  localparam logic [7:0] CTL_OUTMODE = 8'h04;
  localparam logic [7:0] CTL_ONESHOT = 8'h08;
  localparam logic [7:0] CTL_LOAD    = 8'h10;
  localparam logic [7:0] CTL_INMODE  = 8'h20;
  localparam logic [7:0] CTL_SP_OUT  = 8'h40;

  // port b bits toggled by the timers
  localparam logic [7:0] PB_TA = 8'h40;
  localparam logic [7:0] PB_TB = 8'h80;

  localparam int PHASE_ITEMS = 430;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst;

  itia_item_if   item_if ();
  itia_result_if res_if ();
  itia_cfg_if    cfg_if ();

  interval_timer_interrupt_adapter u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .items   (item_if),
    .results (res_if)
  );

  // shadow of the block state
  logic [7:0]  rf_shadow [16];
  logic [15:0] ta_count, tb_count, ta_latch, tb_latch;
  logic [7:0]  icr_flags;
  logic        ta_underflow_pending;
  logic [3:0]  sr_bits_left, sr_bits_queued;

  item_t   stimulus_q [$];
  result_t expected_results [$];
  int      items_queued = 0;
  int      results_checked = 0;
  int      n_errors = 0;

  logic item_taken = 1'b0;
  logic result_taken = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // state after reset or a unit select write
  function automatic void clear_shadow(input logic sel);
    for (int i = 0; i < 16; i++) begin
      rf_shadow[i] = 8'h00;
    end
    rf_shadow[REG_PORT_A] = sel ? PORT_A_UNIT1 : PORT_A_UNIT0;
    rf_shadow[REG_PORT_B] = PORT_B_INIT;
    rf_shadow[REG_DDR_A]  = sel ? DDR_A_UNIT1 : DDR_A_UNIT0;
    ta_count = '0;
    tb_count = '0;
    ta_latch = '0;
    tb_latch = '0;
    icr_flags = '0;
    ta_underflow_pending = 1'b0;
    sr_bits_left = '0;
    sr_bits_queued = '0;
  endfunction

  // latch a flag and set the summary bit when it is unmasked
  function automatic void raise_icr(input logic [7:0] flag);
    icr_flags |= flag;
    if (|(rf_shadow[REG_ICR] & flag)) icr_flags |= FLAG_IRQ;
  endfunction

  // predict the result of one item and advance the shadow state
  function automatic result_t apply_item(input item_t it);
    result_t    r;
    logic [7:0] ctl;
    logic [7:0] d;
    logic       b_counts;
    r = '0;
    d = it.write_data;
    case (it.action)
      ACT_TICK: begin
        if (it.alarm_event) raise_icr(FLAG_ALARM);
        // timer a counts machine cycles unless counting pulses
        ctl = rf_shadow[REG_CTRL_A];
        if (|(ctl & CTL_START) && !(|(ctl & CTL_INMODE))) begin
          ta_count = (ta_count > 16'(it.delta_cycles)) ?
                     ta_count - 16'(it.delta_cycles) : 16'h0000;
          if (ta_count == 16'h0000) begin
            ta_underflow_pending = 1'b1;
            if (|(ctl & CTL_PB_ON) && !(|(ctl & CTL_OUTMODE)))
              rf_shadow[REG_PORT_B] ^= PB_TA;
            if (!(|(ctl & CTL_ONESHOT))) ta_count = ta_latch;
            else rf_shadow[REG_CTRL_A] &= ~CTL_START;
            raise_icr(FLAG_TA);
            // serial shift counts timer a underflows
            if (|(rf_shadow[REG_CTRL_A] & CTL_SP_OUT) && sr_bits_left != 0) begin
              sr_bits_left--;
              if (sr_bits_left == 0) begin
                raise_icr(FLAG_SERIAL);
                if (sr_bits_queued != 0) begin
                  sr_bits_left = sr_bits_queued;
                  sr_bits_queued = '0;
                end
              end
            end
          end
        end
        // timer b counts cycles or timer a underflows
        ctl = rf_shadow[REG_CTRL_B];
        b_counts = 1'b0;
        if (|(ctl & CTL_START)) begin
          if (ctl[6:5] == MODE_CYCLES) begin
            tb_count = (tb_count > 16'(it.delta_cycles)) ?
                       tb_count - 16'(it.delta_cycles) : 16'h0000;
            b_counts = 1'b1;
          end else if (ctl[6:5] == MODE_CASCADE) begin
            if (ta_underflow_pending) begin
              ta_underflow_pending = 1'b0;
              tb_count = tb_count - 16'd1;
            end
            b_counts = 1'b1;
          end
        end
        if (b_counts && tb_count == 16'h0000) begin
          if (|(ctl & CTL_PB_ON) && !(|(ctl & CTL_OUTMODE)))
            rf_shadow[REG_PORT_B] ^= PB_TB;
          if (!(|(ctl & CTL_ONESHOT))) tb_count = tb_latch;
          else rf_shadow[REG_CTRL_B] &= ~CTL_START;
          raise_icr(FLAG_TB);
        end
      end
      ACT_READ: begin
        case (it.reg_index)
          REG_TA_LO: r.read_data = ta_count[7:0];
          REG_TA_HI: r.read_data = ta_count[15:8];
          REG_TB_LO: r.read_data = tb_count[7:0];
          REG_TB_HI: r.read_data = tb_count[15:8];
          REG_ICR: begin
            r.read_data = icr_flags;
            icr_flags = '0;
          end
          default: r.read_data = rf_shadow[it.reg_index];
        endcase
      end
      ACT_WRITE: begin
        case (it.reg_index)
          REG_TA_LO: ta_latch[7:0] = d;
          REG_TA_HI: begin
            ta_latch[15:8] = d;
            if (!(|(rf_shadow[REG_CTRL_A] & CTL_START))) ta_count = ta_latch;
          end
          REG_TB_LO: tb_latch[7:0] = d;
          REG_TB_HI: begin
            tb_latch[15:8] = d;
            if (!(|(rf_shadow[REG_CTRL_B] & CTL_START))) tb_count = tb_latch;
          end
          REG_SERIAL: begin
            if (sr_bits_left == 0) sr_bits_left = SERIAL_BITS;
            else sr_bits_queued = SERIAL_BITS;
            rf_shadow[REG_SERIAL] = d;
          end
          REG_ICR: begin
            if (|(d & FLAG_IRQ)) rf_shadow[REG_ICR] |= d;
            else rf_shadow[REG_ICR] &= ~(d | FLAG_IRQ);
          end
          REG_CTRL_A: begin
            rf_shadow[REG_CTRL_A] = d & CTRL_STORE_MASK;
            if (|(d & CTL_LOAD)) ta_count = ta_latch;
          end
          REG_CTRL_B: begin
            rf_shadow[REG_CTRL_B] = d & CTRL_STORE_MASK;
            if (|(d & CTL_LOAD)) tb_count = tb_latch;
          end
          default: rf_shadow[it.reg_index] = d;
        endcase
      end
      default: ;
    endcase
    r.irq_pending  = |(icr_flags & FLAG_IRQ);
    r.port_b_value = rf_shadow[REG_PORT_B];
    return r;
  endfunction

  function automatic logic [7:0] set_bits(input logic [7:0] v, input logic [7:0] mask,
                                          input logic on);
    return on ? (v | mask) : (v & ~mask);
  endfunction

  task automatic queue_item(input logic [1:0] act, input logic [3:0] idx,
                            input logic [7:0] data, input logic [7:0] delta,
                            input logic alarm);
    item_t it;
    it.action       = act;
    it.reg_index    = idx;
    it.write_data   = data;
    it.delta_cycles = delta;
    it.alarm_event  = alarm;
    stimulus_q.push_back(it);
    items_queued++;
  endtask

  // timer setup followed by a run of ticks, reads and stray writes
  task automatic queue_timer_burst();
    logic [7:0] ctl;
    int         n;
    int         pick;
    logic [3:0] idx;
    queue_item(ACT_WRITE, REG_TA_LO, 8'($urandom_range(0, 12)), 8'($urandom), 1'($urandom));
    queue_item(ACT_WRITE, REG_TA_HI, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00,
               8'($urandom), 1'($urandom));
    queue_item(ACT_WRITE, REG_TB_LO, 8'($urandom_range(0, 12)), 8'($urandom), 1'($urandom));
    queue_item(ACT_WRITE, REG_TB_HI, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00,
               8'($urandom), 1'($urandom));
    queue_item(ACT_WRITE, REG_ICR, set_bits(8'($urandom), FLAG_IRQ, $urandom_range(0, 9) < 7),
               8'($urandom), 1'($urandom));
    if ($urandom_range(0, 9) < 4) begin
      queue_item(ACT_WRITE, REG_SERIAL, 8'($urandom), 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) < 4)
        queue_item(ACT_WRITE, REG_SERIAL, 8'($urandom), 8'($urandom), 1'($urandom));
    end
    // timer a mostly running
    ctl = 8'($urandom);
    ctl = set_bits(ctl, CTL_START, $urandom_range(0, 9) < 8);
    ctl = set_bits(ctl, CTL_ONESHOT, $urandom_range(0, 3) == 0);
    ctl = set_bits(ctl, CTL_INMODE, $urandom_range(0, 6) == 0);
    ctl = set_bits(ctl, CTL_LOAD, $urandom_range(0, 3) != 0);
    queue_item(ACT_WRITE, REG_CTRL_A, ctl, 8'($urandom), 1'($urandom));
    // timer b mostly counting cycles or cascaded
    ctl = 8'($urandom);
    ctl = set_bits(ctl, CTL_START, $urandom_range(0, 19) < 17);
    ctl = set_bits(ctl, CTL_ONESHOT, $urandom_range(0, 3) == 0);
    ctl = set_bits(ctl, CTL_LOAD, $urandom_range(0, 3) != 0);
    pick = $urandom_range(0, 19);
    ctl[6:5] = (pick < 10) ? MODE_CYCLES : (pick < 17) ? MODE_CASCADE : 2'($urandom);
    queue_item(ACT_WRITE, REG_CTRL_B, ctl, 8'($urandom), 1'($urandom));
    n = $urandom_range(8, 40);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        queue_item(ACT_TICK, 4'($urandom), 8'($urandom),
                   ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
                   $urandom_range(0, 7) == 0);
      end else if (pick < 9) begin
        case ($urandom_range(0, 6))
          0: idx = REG_ICR;
          1: idx = REG_TA_LO;
          2: idx = REG_TA_HI;
          3: idx = REG_TB_LO;
          4: idx = REG_TB_HI;
          5: idx = REG_PORT_B;
          default: idx = 4'($urandom);
        endcase
        queue_item(ACT_READ, idx, 8'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        queue_item(ACT_WRITE, 4'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // wait until every queued item has returned its result
  task automatic wait_drained();
    do @(negedge clk); while (results_checked != items_queued);
  endtask

  task automatic write_unit(input logic sel);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.unit_select <= sel;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    clear_shadow(sel);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // item driver and result ready, both changing on the falling edge
  always @(negedge clk) begin : driver
    item_t nxt;
    if (rst) begin
      item_if.valid <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      if (!item_if.valid || item_taken) begin
        if (send_gap > 0) begin
          item_if.valid <= 1'b0;
          send_gap--;
        end else if (stimulus_q.size() > 0) begin
          nxt = stimulus_q.pop_front();
          item_if.valid        <= 1'b1;
          item_if.action       <= nxt.action;
          item_if.reg_index    <= nxt.reg_index;
          item_if.write_data   <= nxt.write_data;
          item_if.delta_cycles <= nxt.delta_cycles;
          item_if.alarm_event  <= nxt.alarm_event;
          if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 16);
        end else begin
          item_if.valid <= 1'b0;
        end
      end
      // result stall drawn after each transfer
      if (result_taken) begin
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : $urandom_range(0, 16);
      end
      if (recv_stall > 0) begin
        res_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // check result transfers, then predict accepted items
  always @(posedge clk) begin : monitor
    result_t want;
    item_t   got;
    if (rst) begin
      item_taken <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      item_taken <= item_if.valid && item_if.ready;
      result_taken <= res_if.valid && res_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result waiting");
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (res_if.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, res_if.read_data);
            n_errors++;
          end
          if (res_if.irq_pending !== want.irq_pending) begin
            $error("irq_pending: expected %0b, got %0b", want.irq_pending,
                   res_if.irq_pending);
            n_errors++;
          end
          if (res_if.port_b_value !== want.port_b_value) begin
            $error("port_b_value: expected %0h, got %0h", want.port_b_value,
                   res_if.port_b_value);
            n_errors++;
          end
        end
      end
      if (item_if.valid && item_if.ready) begin
        got.action       = item_if.action;
        got.reg_index    = item_if.reg_index;
        got.write_data   = item_if.write_data;
        got.delta_cycles = item_if.delta_cycles;
        got.alarm_event  = item_if.alarm_event;
        expected_results.push_back(apply_item(got));
      end
    end
  end

  // end the run when no transfer happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus sequence
  initial begin : stimulus
    logic sel;
    int   phase_end;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.action = ACT_TICK;
    item_if.reg_index = '0;
    item_if.write_data = '0;
    item_if.delta_cycles = '0;
    item_if.alarm_event = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.unit_select = 1'b1;
    clear_shadow(1'b1);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: port values, alarm, both timers, cascade, one-shot, idle modes
    queue_item(ACT_READ, REG_PORT_A, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_READ, REG_DDR_A, 8'hFF, 8'hFF, 1'b1);
    queue_item(ACT_WRITE, REG_ICR, FLAG_IRQ | FLAG_TA | FLAG_TB | FLAG_ALARM | FLAG_SERIAL,
               8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_TA_LO, 8'h03, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_TA_HI, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_CTRL_A, CTL_START | CTL_PB_ON | CTL_LOAD, 8'h00, 1'b0);
    queue_item(ACT_TICK, 4'h0, 8'h00, 8'h01, 1'b1);
    queue_item(ACT_TICK, 4'hF, 8'hFF, 8'hFF, 1'b0);
    queue_item(ACT_READ, REG_ICR, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_READ, REG_TA_LO, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_TB_LO, 8'h01, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_TB_HI, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_CTRL_B, CTL_SP_OUT | CTL_START | CTL_PB_ON, 8'h00, 1'b0);
    queue_item(ACT_TICK, 4'h0, 8'h00, 8'h03, 1'b0);
    queue_item(ACT_WRITE, REG_CTRL_A, CTL_START | CTL_ONESHOT | CTL_INMODE, 8'h00, 1'b0);
    queue_item(ACT_TICK, 4'h0, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_CTRL_B, CTL_INMODE | CTL_START, 8'h00, 1'b0);
    queue_item(ACT_TICK, 4'h0, 8'h00, 8'hFF, 1'b1);
    queue_item(ACT_WRITE, REG_ICR, FLAG_TA, 8'h00, 1'b0);
    queue_item(ACT_WRITE, REG_CTRL_A, CTL_START | CTL_ONESHOT | CTL_LOAD, 8'h00, 1'b0);
    queue_item(ACT_TICK, 4'h0, 8'h00, 8'hFF, 1'b0);
    queue_item(ACT_WRITE, REG_SERIAL, 8'hFF, 8'h00, 1'b0);
    queue_item(ACT_WRITE, 4'd3, 8'hFF, 8'h00, 1'b0);
    queue_item(ACT_READ, 4'd3, 8'h00, 8'h00, 1'b0);
    queue_item(ACT_IDLE, 4'hF, 8'hFF, 8'hFF, 1'b1);
    queue_item(ACT_READ, REG_ICR, 8'h00, 8'h00, 1'b0);
    wait_drained();

    // random phases under alternating unit selects
    for (int p = 0; p < 4; p++) begin
      sel = p[0];
      write_unit(sel);
      queue_item(ACT_READ, REG_PORT_A, 8'($urandom), 8'($urandom), 1'($urandom));
      queue_item(ACT_READ, REG_PORT_B, 8'($urandom), 8'($urandom), 1'($urandom));
      queue_item(ACT_READ, REG_DDR_A, 8'($urandom), 8'($urandom), 1'($urandom));
      phase_end = items_queued + PHASE_ITEMS;
      while (items_queued < phase_end) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_timer_burst();
        end else begin
          repeat ($urandom_range(5, 15))
            queue_item(2'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom));
        end
        // hold off now and then until the block has drained
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/itia_pkg.sv
sv/itia_ifs.sv
sv/itia_core.sv
sv/interval_timer_interrupt_adapter.sv
dv/tb_top.sv
